// ===== rtl/circle_inversion_mirrored_macros.svh =====
// Assertion macros shared by the circle inversion RTL.
`ifndef CIRCLE_INVERSION_MIRRORED_MACROS_SVH
`define CIRCLE_INVERSION_MIRRORED_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define CIM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("circle inversion assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define CIM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("circle inversion assertion failed");
`else
`define CIM_ASSERT_NOW(lbl, ante, cons)
`define CIM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/cim_pkg.sv =====
// Package with widths, codes and side-band types of the circle inversion block.
`timescale 1ns / 1ps
package cim_pkg;

	localparam int CW  = 32;  // coordinate width
	localparam int RW  = 31;  // radius width
	localparam int DW  = 34;  // signed offset from the inversion centre
	localparam int AW  = 33;  // magnitude of that offset
	localparam int RSW = 48;  // squared inversion radius
	localparam int SW  = 66;  // squared distance
	localparam int EW  = 68;  // divisor width
	localparam int QB  = 41;  // quotient bits kept by each divider lane
	localparam int HW  = 24;  // split point of the squared radius for the products

	localparam logic [1:0] REG_CENTRE_X = 2'd0;
	localparam logic [1:0] REG_CENTRE_Y = 2'd1;
	localparam logic [1:0] REG_RADIUS_SQ = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_CENTRE = 2'd1;
	localparam logic [1:0] STAT_SAT    = 2'd2;

	typedef struct packed {
		logic [3:0] colour;
		logic       last;
		logic       negx;
		logic       negy;
		logic       zero;
	} side_t;

endpackage

// ===== rtl/cim_div_lane.sv =====
// Pipelined restoring divider lane: one quotient bit per stage, with overflow detect.
`timescale 1ns / 1ps
module cim_div_lane #(
	parameter int NW = 97
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [NW-1:0]            num,
	input  logic [cim_pkg::EW-1:0]   den,
	output logic [cim_pkg::QB-1:0]   quo,
	output logic                     big
);

	localparam int EW  = cim_pkg::EW;
	localparam int QB  = cim_pkg::QB;
	localparam int CWD = ((NW > EW + QB) ? NW : EW + QB) + 1;

	logic [EW-1:0] rem_s [0:QB];
	logic [QB-1:0] lo_s  [0:QB];
	logic [QB-1:0] q_s   [0:QB];
	logic [EW-1:0] den_s [0:QB];
	logic          big_s [0:QB];

	logic [CWD-1:0] num_ext;
	logic [CWD-1:0] den_ext;
	logic [NW-1:0]  num_top;

	assign num_ext = CWD'(num);
	assign den_ext = CWD'(den) << QB;
	assign num_top = num >> QB;

	// The quotient overflows the kept bits exactly when num >= den * 2^QB.
	always_ff @(posedge clk) begin
		if (en) begin
			big_s[0] <= (num_ext >= den_ext);
			rem_s[0] <= num_top[EW-1:0];
			lo_s[0]  <= num[QB-1:0];
			q_s[0]   <= '0;
			den_s[0] <= den;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [EW:0] part;
		logic [EW:0] diff;
		logic        ge;
		assign part = {rem_s[k-1], lo_s[k-1][QB-k]};
		assign diff = part - {1'b0, den_s[k-1]};
		assign ge   = (part >= {1'b0, den_s[k-1]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[EW-1:0] : part[EW-1:0];
				q_s[k]   <= {q_s[k-1][QB-2:0], ge};
				lo_s[k]  <= lo_s[k-1];
				den_s[k] <= den_s[k-1];
				big_s[k] <= big_s[k-1];
			end
		end
	end

	assign quo = q_s[QB];
	assign big = big_s[QB];

endmodule

// ===== rtl/circle_inversion_mirrored.sv =====
// Top level of the circle inversion block with its mirrored second result.
`timescale 1ns / 1ps
// The block takes one circle per input item and returns two result items: the
// circle's image under inversion in the configured circle, then the image of the
// same circle mirrored across x = 0, which carries tlast. A new input item is
// taken only as the last one's mirrored result enters the datapath, since the
// single datapath produces one result item per cycle while not stalled. Without
// stalls the mirrored result item follows the first in the next cycle. Items
// pass the setup stages and then the 41 stages of the restoring divider lanes
// that form the three quotients in parallel. The whole pipeline holds while the
// output register waits on m_tready, so nothing is lost under back-pressure;
// during such a stall one more input item is still taken if the input register
// is empty. Configuration writes are always ready and must only be made while
// no items are in flight. status is carried in m_tuser: 0 ok, 1 circle centred
// on the inversion centre (geometry fields zero), 2 a field was saturated.
`include "circle_inversion_mirrored_macros.svh"
module circle_inversion_mirrored #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// circle_x[31:0], circle_y[63:32], circle_radius[94:64], colour[98:95], zero fill
	input  logic [103:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// image_x[31:0], image_y[63:32], image_radius[94:64], colour_out[98:95], zero fill
	output logic [103:0]  m_tdata,
	// status[1:0]
	output logic [1:0]    m_tuser,
	output logic          m_tlast,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [47:0]   cfg_data
);

	localparam int CW  = cim_pkg::CW;
	localparam int RW  = cim_pkg::RW;
	localparam int DW  = cim_pkg::DW;
	localparam int AW  = cim_pkg::AW;
	localparam int RSW = cim_pkg::RSW;
	localparam int SW  = cim_pkg::SW;
	localparam int EW  = cim_pkg::EW;
	localparam int QB  = cim_pkg::QB;
	localparam int HW  = cim_pkg::HW;
	localparam int PW  = AW + RSW;        // product of a magnitude and the squared radius
	localparam int NW  = PW + FRAC_BITS;  // dividend width

	// Configuration registers.
	logic signed [CW-1:0] centre_x_q;
	logic signed [CW-1:0] centre_y_q;
	logic [RSW-1:0]       rsq_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= '0;
			centre_y_q <= '0;
			rsq_q      <= RSW'(1) << FRAC_BITS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cim_pkg::REG_CENTRE_X:  centre_x_q <= cfg_data[CW-1:0];
				cim_pkg::REG_CENTRE_Y:  centre_y_q <= cfg_data[CW-1:0];
				cim_pkg::REG_RADIUS_SQ: rsq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves when the output register is free or being emptied.
	logic adv;
	logic out_v_q;
	assign adv = !out_v_q || m_tready;

	// Input item register; phase_q selects the plain or mirrored result.
	logic          item_v_q;
	logic          phase_q;
	logic [CW-1:0] in_x_q;
	logic [CW-1:0] in_y_q;
	logic [RW-1:0] in_r_q;
	logic [3:0]    in_c_q;
	logic          in_acc;

	assign s_tready = !item_v_q || (phase_q && adv);
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_q <= 1'b0;
			phase_q  <= 1'b0;
		end else if (in_acc) begin
			item_v_q <= 1'b1;
			phase_q  <= 1'b0;
		end else if (item_v_q && adv) begin
			if (phase_q) begin
				item_v_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_x_q <= s_tdata[31:0];
			in_y_q <= s_tdata[63:32];
			in_r_q <= s_tdata[94:64];
			in_c_q <= s_tdata[98:95];
		end
	end

	// Stage 1: offset from the inversion centre, as magnitude and sign.
	logic signed [DW-1:0] x_ext, x_sel, y_ext, dx, dy;
	assign x_ext = DW'(signed'(in_x_q));
	assign y_ext = DW'(signed'(in_y_q));
	assign x_sel = phase_q ? -x_ext : x_ext;
	assign dx    = x_sel - DW'(centre_x_q);
	assign dy    = y_ext - DW'(centre_y_q);

	logic           v_s1;
	logic [AW-1:0]  ax_s1, ay_s1;
	logic [RW-1:0]  r_s1;
	cim_pkg::side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1          <= dx[DW-1] ? AW'(-dx) : AW'(dx);
			ay_s1          <= dy[DW-1] ? AW'(-dy) : AW'(dy);
			r_s1           <= in_r_q;
			side_s1.colour <= in_c_q;
			side_s1.last   <= phase_q;
			side_s1.negx   <= dx[DW-1];
			side_s1.negy   <= dy[DW-1];
			side_s1.zero   <= 1'b0;
		end
	end

	// Stage 2: squares and the split products with the squared radius.
	logic [HW-1:0]       rs_lo, rs_hi;
	assign rs_lo = rsq_q[HW-1:0];
	assign rs_hi = rsq_q[RSW-1:HW];

	logic                v_s2;
	logic [2*AW-1:0]     sxx_s2, syy_s2;
	logic [2*RW-1:0]     rr_s2;
	logic [AW+HW-1:0]    pxl_s2, pxh_s2, pyl_s2, pyh_s2;
	logic [RW+HW-1:0]    prl_s2, prh_s2;
	cim_pkg::side_t      side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sxx_s2  <= ax_s1 * ax_s1;
			syy_s2  <= ay_s1 * ay_s1;
			rr_s2   <= r_s1 * r_s1;
			pxl_s2  <= ax_s1 * rs_lo;
			pxh_s2  <= ax_s1 * rs_hi;
			pyl_s2  <= ay_s1 * rs_lo;
			pyh_s2  <= ay_s1 * rs_hi;
			prl_s2  <= r_s1 * rs_lo;
			prh_s2  <= r_s1 * rs_hi;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: squared distance and the scaled dividends.
	logic [PW-1:0] px, py, pr;
	assign px = {pxh_s2, {HW{1'b0}}} + PW'(pxl_s2);
	assign py = {pyh_s2, {HW{1'b0}}} + PW'(pyl_s2);
	assign pr = PW'({prh_s2, {HW{1'b0}}}) + PW'(prl_s2);

	logic           v_s3;
	logic [SW-1:0]  s_s3;
	logic [2*RW-1:0] r2_s3;
	logic [NW-1:0]  nx_s3, ny_s3, nr_s3;
	cim_pkg::side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s3    <= sxx_s2 + syy_s2;
			r2_s3   <= rr_s2;
			nx_s3   <= NW'(px) << FRAC_BITS;
			ny_s3   <= NW'(py) << FRAC_BITS;
			nr_s3   <= NW'(pr) << FRAC_BITS;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: divisor. When the near end sits on the inversion centre the
	// difference vanishes and four times the squared distance is used instead.
	logic          dneg;
	logic [SW-1:0] r2_ext, diff;
	assign r2_ext = SW'(r2_s3);
	assign dneg   = (s_s3 < r2_ext);
	assign diff   = dneg ? (r2_ext - s_s3) : (s_s3 - r2_ext);

	logic           v_s4;
	logic [EW-1:0]  e_s4;
	logic [NW-1:0]  nx_s4, ny_s4, nr_s4;
	cim_pkg::side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s4           <= (diff == '0) ? {s_s3, 2'b00} : EW'(diff);
			nx_s4          <= nx_s3;
			ny_s4          <= ny_s3;
			nr_s4          <= nr_s3;
			side_s4.colour <= side_s3.colour;
			side_s4.last   <= side_s3.last;
			side_s4.negx   <= side_s3.negx ^ dneg;
			side_s4.negy   <= side_s3.negy ^ dneg;
			side_s4.zero   <= (s_s3 == '0);
		end
	end

	// Divider lanes for the two offsets and the radius.
	logic [QB-1:0] qx, qy, qr;
	logic          bx, by, br;

	cim_div_lane #(.NW(NW)) u_div_x (
		.clk(clk), .en(adv), .num(nx_s4), .den(e_s4), .quo(qx), .big(bx)
	);
	cim_div_lane #(.NW(NW)) u_div_y (
		.clk(clk), .en(adv), .num(ny_s4), .den(e_s4), .quo(qy), .big(by)
	);
	cim_div_lane #(.NW(NW)) u_div_r (
		.clk(clk), .en(adv), .num(nr_s4), .den(e_s4), .quo(qr), .big(br)
	);

	// Valid bits and side-band fields travel alongside the divider stages.
	logic           v_d    [0:QB];
	cim_pkg::side_t side_d [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else if (adv) begin
			v_d[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_s4;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k] <= 1'b0;
			end else if (adv) begin
				v_d[k] <= v_d[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	// Centre plus or minus the quotient, clamped; bit 32 flags a clamp.
	function automatic logic [CW:0] place(input logic [CW-1:0] c, input logic [QB-1:0] q,
			input logic big, input logic neg);
		logic signed [QB+2:0] v;
		logic signed [QB+2:0] lim_hi;
		logic signed [QB+2:0] lim_lo;
		lim_hi = (QB+3)'(signed'({1'b0, {(CW-1){1'b1}}}));
		lim_lo = (QB+3)'(signed'({1'b1, {(CW-1){1'b0}}}));
		v = neg ? ((QB+3)'(signed'(c)) - (QB+3)'(q)) : ((QB+3)'(signed'(c)) + (QB+3)'(q));
		if (big) begin
			place = {1'b1, neg ? lim_lo[CW-1:0] : lim_hi[CW-1:0]};
		end else if (v > lim_hi) begin
			place = {1'b1, lim_hi[CW-1:0]};
		end else if (v < lim_lo) begin
			place = {1'b1, lim_lo[CW-1:0]};
		end else begin
			place = {1'b0, v[CW-1:0]};
		end
	endfunction

	cim_pkg::side_t sd;
	logic [CW:0]    px_res, py_res;
	logic           r_sat;
	logic [RW-1:0]  r_res;

	assign sd     = side_d[QB];
	assign px_res = place(centre_x_q, qx, bx, sd.negx);
	assign py_res = place(centre_y_q, qy, by, sd.negy);
	assign r_sat  = br || (qr[QB-1:RW] != '0);
	assign r_res  = r_sat ? {RW{1'b1}} : qr[RW-1:0];

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_d[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tlast <= sd.last;
			if (sd.zero) begin
				m_tdata <= {5'b0, sd.colour, {(RW+2*CW){1'b0}}};
				m_tuser <= cim_pkg::STAT_CENTRE;
			end else begin
				m_tdata <= {5'b0, sd.colour, r_res, py_res[CW-1:0], px_res[CW-1:0]};
				m_tuser <= (px_res[CW] || py_res[CW] || r_sat) ? cim_pkg::STAT_SAT
					: cim_pkg::STAT_OK;
			end
		end
	end

	assign m_tvalid = out_v_q;

	// A taken item blocks the input for its second, mirrored result.
	`CIM_ASSERT_NEXT(a_two_cycle_input, s_tvalid && s_tready, !s_tready)
	// A circle centred on the inversion centre gives zero geometry.
	`CIM_ASSERT_NOW(a_centre_zero, m_tvalid && (m_tuser == cim_pkg::STAT_CENTRE),
		m_tdata[94:0] == 95'd0)
	// The status code is always one of the defined codes.
	`CIM_ASSERT_NOW(a_status_code, m_tvalid, (m_tuser == cim_pkg::STAT_OK)
		|| (m_tuser == cim_pkg::STAT_CENTRE) || (m_tuser == cim_pkg::STAT_SAT))

endmodule

// ===== test/circle_inversion_checker.sv =====
// Checker for the circle inversion block: predicts result items and compares them.
`timescale 1ns / 1ps
module circle_inversion_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         m_tlast,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [47:0]  cfg_data,
	output int           failures,
	output int           pending
);

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [30:0] r;
		logic [3:0]  colour;
		logic [1:0]  status;
		logic        last;
	} image_t;

	logic signed [63:0] inv_cx, inv_cy;
	logic [47:0]        inv_rs;
	image_t             image_q[$];

	assign pending = image_q.size();

	// Centre plus or minus a quotient, clamped to the signed 32-bit range.
	function automatic logic [31:0] place(input logic signed [63:0] c, input logic [127:0] q,
			input logic neg, inout logic sat);
		logic signed [63:0] v;
		if (q > (128'd1 << 40)) begin
			sat = 1'b1;
			v = neg ? -64'sd2147483648 : 64'sd2147483647;
		end else begin
			v = neg ? c - signed'(q[63:0]) : c + signed'(q[63:0]);
			if (v > 64'sd2147483647) begin
				v = 64'sd2147483647;
				sat = 1'b1;
			end
			if (v < -64'sd2147483648) begin
				v = -64'sd2147483648;
				sat = 1'b1;
			end
		end
		return v[31:0];
	endfunction

	function automatic image_t invert_circle(input logic signed [63:0] x, input logic signed [63:0] y,
			input logic [30:0] r, input logic [3:0] colour, input logic last);
		logic signed [63:0] dx, dy, mx, my;
		logic [127:0]       ax, ay, rr, s, r2, e, q;
		logic               dneg, sat;
		image_t             o;
		dx = x - inv_cx;
		dy = y - inv_cy;
		mx = dx < 0 ? -dx : dx;
		my = dy < 0 ? -dy : dy;
		ax = {64'd0, mx};
		ay = {64'd0, my};
		rr = {97'd0, r};
		o.colour = colour;
		o.last = last;
		s = ax * ax + ay * ay;
		if (s == 0) begin
			o.x = '0;
			o.y = '0;
			o.r = '0;
			o.status = cim_pkg::STAT_CENTRE;
			return o;
		end
		sat = 1'b0;
		r2 = rr * rr;
		dneg = s < r2;
		e = dneg ? r2 - s : s - r2;
		// An endpoint sitting on the inversion centre: use the far end only.
		if (e == 0)
			e = s << 2;
		q = ((ax * inv_rs) << 16) / e;
		o.x = place(inv_cx, q, (dx < 0) != dneg, sat);
		q = ((ay * inv_rs) << 16) / e;
		o.y = place(inv_cy, q, (dy < 0) != dneg, sat);
		q = ((rr * inv_rs) << 16) / e;
		if (q > 128'h7FFFFFFF) begin
			o.r = 31'h7FFFFFFF;
			sat = 1'b1;
		end else begin
			o.r = q[30:0];
		end
		o.status = sat ? cim_pkg::STAT_SAT : cim_pkg::STAT_OK;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_cx <= '0;
			inv_cy <= '0;
			inv_rs <= 48'd65536;
			failures <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cim_pkg::REG_CENTRE_X: inv_cx <= {{32{cfg_data[31]}}, cfg_data[31:0]};
					cim_pkg::REG_CENTRE_Y: inv_cy <= {{32{cfg_data[31]}}, cfg_data[31:0]};
					cim_pkg::REG_RADIUS_SQ: inv_rs <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				logic signed [63:0] cx, cy;
				cx = {{32{s_tdata[31]}}, s_tdata[31:0]};
				cy = {{32{s_tdata[63]}}, s_tdata[63:32]};
				image_q.push_back(invert_circle(cx, cy, s_tdata[94:64], s_tdata[98:95], 1'b0));
				image_q.push_back(invert_circle(-cx, cy, s_tdata[94:64], s_tdata[98:95], 1'b1));
			end
			if (m_tvalid && m_tready) begin
				image_t want;
				if (image_q.size() == 0) begin
					$display("%0t: unexpected result item data=%h user=%h last=%b",
						$time, m_tdata, m_tuser, m_tlast);
					failures <= failures + 1;
				end else begin
					want = image_q.pop_front();
					if (want.x !== m_tdata[31:0] || want.y !== m_tdata[63:32]
							|| want.r !== m_tdata[94:64] || want.colour !== m_tdata[98:95]
							|| want.status !== m_tuser || want.last !== m_tlast) begin
						$display("%0t: mismatch expected x=%h y=%h r=%h c=%h st=%0d last=%b",
							$time, want.x, want.y, want.r, want.colour, want.status, want.last);
						$display("%0t:          actual   x=%h y=%h r=%h c=%h st=%0d last=%b",
							$time, m_tdata[31:0], m_tdata[63:32], m_tdata[94:64],
							m_tdata[98:95], m_tuser, m_tlast);
						failures <= failures + 1;
					end
				end
			end
		end
	end
endmodule

// ===== test/tb_circle_inversion_mirrored.sv =====
// Testbench top for the circle inversion block: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_circle_inversion_mirrored;

	localparam int CYCLE_LIMIT = 400000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b1;
	logic [103:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = cim_pkg::REG_CENTRE_X;
	logic [47:0]  cfg_data = '0;
	int           failures, pending;
	int           cycles = 0;
	bit           idle_on = 1'b1;
	bit           start_hold = 1'b0;
	logic [31:0]  cur_cx = '0, cur_cy = '0;

	always #6 clk = ~clk;

	circle_inversion_mirrored u_top (.*);

	circle_inversion_checker u_check (.*);

	// Watchdog: a run that stalls forever, or never drains its expectations, fails here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[circle_inversion_mirrored] ERROR");
			$finish;
		end
	end

	// Receiver side. Short random stalls while idling is enabled, plus one long
	// hold requested by the stimulus so that the pipeline fills and s_tready drops.
	initial begin
		forever begin
			@(posedge clk);
			if (start_hold) begin
				start_hold = 1'b0;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Register writes happen only when nothing is in flight.
	task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_inversion(input logic [31:0] cx, input logic [31:0] cy,
			input logic [47:0] rs);
		write_reg(cim_pkg::REG_CENTRE_X, {16'd0, cx});
		write_reg(cim_pkg::REG_CENTRE_Y, {16'd0, cy});
		write_reg(cim_pkg::REG_RADIUS_SQ, rs);
		cur_cx = cx;
		cur_cy = cy;
	endtask

	// Offer one circle and hold it until taken. A random gap may precede it.
	task automatic send_circle(input logic [31:0] x, input logic [31:0] y,
			input logic [30:0] r, input logic [3:0] colour);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, colour, r, y, x};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Random circle. Most items sit near the inversion centre so that the
	// quotients stay in range; the rest hit the special geometries or full range.
	task automatic send_random;
		logic [31:0] dx, dy, k;
		logic [30:0] r;
		case ($urandom_range(0, 9))
			0, 1: send_circle($urandom, $urandom, 31'($urandom), 4'($urandom));
			2: begin
				// Radius equal to the distance: a 3-4-5 triangle scaled.
				k = $urandom_range(1, 4000);
				send_circle(cur_cx + 3 * k, cur_cy - 4 * k, 31'(5 * k), 4'($urandom));
			end
			3: send_circle(cur_cx, cur_cy, 31'($urandom), 4'($urandom));
			default: begin
				dx = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
				dy = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
				r = 31'($urandom_range(0, 32'h0006_0000));
				send_circle(cur_cx + dx, cur_cy + dy, r, 4'($urandom));
			end
		endcase
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset setting: unit circle at the origin.
		send_circle(32'h7FFF_FFFF, 32'h0, 31'h0001_0000, 4'd0);
		send_circle(32'h8000_0000, 32'h0, 31'h0001_0000, 4'd15);
		send_circle(32'h0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 4'd5);
		send_circle(32'h0, 32'h8000_0000, 31'h0, 4'd10);
		send_circle(32'h0, 32'h0, 31'h0002_0000, 4'd3);           // centred on the centre
		send_circle(32'h0003_0000, 32'h0004_0000, 31'h0005_0000, 4'd7); // endpoint at centre
		send_circle(32'h0000_8000, 32'h0, 31'h0002_0000, 4'd9);    // encloses the centre
		send_circle(32'h0002_0000, 32'hFFFE_0000, 31'h0000_8000, 4'd1);
		send_circle(32'h0000_0001, 32'h0000_0001, 31'h0, 4'd2);    // tiny distance, saturates
		send_circle(32'hFFFF_FFFF, 32'h0, 31'h7FFF_FFFF, 4'd4);
		send_circle(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 4'd12);
		drain();

		// Extreme centre and largest squared radius.
		set_inversion(32'h8000_0000, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_circle(32'h8000_0000, 32'h7FFF_FFFF, 31'h0001_0000, 4'd6);
		send_circle(32'h7FFF_FFFF, 32'h8000_0000, 31'h0, 4'd8);
		send_circle(32'h8000_0000, 32'h0, 31'h7FFF_FFFF, 4'd11);
		repeat (40) send_random();
		drain();

		// Zero squared radius: everything collapses onto the centre.
		set_inversion(32'h0001_0000, 32'hFFFF_0000, 48'd0);
		send_circle(32'h0001_0000, 32'hFFFF_0000, 31'h0003_0000, 4'd13);
		repeat (30) send_random();
		drain();

		// Random settings with long receiver hold and a full sender pause.
		for (int phase = 0; phase < 5; phase++) begin
			set_inversion($urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
				$urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
				{16'd0, $urandom_range(32'h0000_4000, 32'h0010_0000)});
			if (phase == 1)
				start_hold = 1'b1;
			repeat (50) send_random();
			if (phase == 2) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			repeat (50) send_random();
			drain();
		end

		// Final stretch at full rate on both sides.
		set_inversion(32'h0, 32'h0, 48'h0001_0000);
		idle_on = 1'b0;
		repeat (70) send_random();
		drain();

		if (failures == 0)
			$display("[circle_inversion_mirrored] OK");
		else
			$display("[circle_inversion_mirrored] ERROR");
		$finish;
	end
endmodule
